@@ hdl/rfr_pkg.sv @@
`default_nettype none

package rfr_pkg;

  // Queue between the front and the back part.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned DEF_MAX_COLUMNS = 4096;
  localparam int unsigned DEF_MAX_ROWS    = 4096;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OFFSET_X    = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y    = 3'd1;
  localparam logic [2:0] CFG_CELL_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_CELL_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_RADIUS      = 3'd4;
  localparam logic [2:0] CFG_AMPLITUDE   = 3'd5;
  localparam logic [2:0] CFG_DEGREE      = 3'd6;

  localparam logic [31:0] RST_OFFSET = 32'd0;
  localparam logic [30:0] RST_SPAN   = 31'd65536;
  localparam logic [31:0] RST_AMP    = 32'd0;
  localparam logic [15:0] RST_DEGREE = 16'd256;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Odd Taylor coefficients of sin(pi/2 * x) in Q30.
  localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3 = -32'sd693598669;
  localparam logic signed [31:0] SIN_C5 = 32'sd85569304;
  localparam logic signed [31:0] SIN_C7 = -32'sd5026995;
  localparam logic signed [31:0] SIN_C9 = 32'sd172272;

  // One item as it travels from the front part to the back part.
  typedef struct packed {
    logic [31:0] alt;
    logic        pre_in;
    logic [30:0] ax;
    logic [30:0] ay;
  } item_t;

  // 2^(-2^-(k+1)) in Q30.
  function automatic logic [29:0] exp_tab(input logic [3:0] k);
    logic [29:0] v;
    case (k)
      4'd0:    v = 30'd759250125;
      4'd1:    v = 30'd902905697;
      4'd2:    v = 30'd984625594;
      4'd3:    v = 30'd1028218693;
      4'd4:    v = 30'd1050733751;
      4'd5:    v = 30'd1062175491;
      4'd6:    v = 30'd1067942999;
      4'd7:    v = 30'd1070838486;
      4'd8:    v = 30'd1072289186;
      4'd9:    v = 30'd1073015247;
      4'd10:   v = 30'd1073378474;
      4'd11:   v = 30'd1073560134;
      4'd12:   v = 30'd1073650975;
      4'd13:   v = 30'd1073696399;
      4'd14:   v = 30'd1073719111;
      default: v = 30'd1073730467;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rfr_front.sv @@
`default_nettype none

module rfr_front #(
  parameter int unsigned MAX_COLUMNS = rfr_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = rfr_pkg::DEF_MAX_ROWS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [11:0]                     column_i,
  input  wire logic [11:0]                     row_i,
  input  wire logic [31:0]                     current_altitude_i,
  input  wire logic [31:0]                     offset_x_i,
  input  wire logic [31:0]                     offset_y_i,
  input  wire logic [30:0]                     cell_width_i,
  input  wire logic [30:0]                     cell_height_i,
  input  wire logic [30:0]                     radius_i,
  input  wire logic [rfr_pkg::FIFO_CNT_W-1:0]  fifo_free_i,
  output logic                                 push_o,
  output rfr_pkg::item_t                       push_item_o
);

  logic        vld_a_q, vld_b_q;
  logic [42:0] px_q, py_q;
  logic [31:0] alt_a_q;
  logic        rng_a_q;
  rfr_pkg::item_t item_b_q;

  logic        accept;
  logic [rfr_pkg::FIFO_CNT_W-1:0] busy;
  logic [44:0] dx, dy, ax, ay;
  logic        pre_in;

  // Items already in flight hold a queue slot each, so the queue never overflows.
  assign busy       = rfr_pkg::FIFO_CNT_W'(vld_a_q) + rfr_pkg::FIFO_CNT_W'(vld_b_q);
  assign in_stall_o = (busy >= fifo_free_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign dx = {2'b00, px_q} + {{13{offset_x_i[31]}}, offset_x_i};
  assign dy = {2'b00, py_q} + {{13{offset_y_i[31]}}, offset_y_i};
  assign ax = dx[44] ? (45'd0 - dx) : dx;
  assign ay = dy[44] ? (45'd0 - dy) : dy;
  assign pre_in = rng_a_q && (ax < {14'd0, radius_i}) && (ay < {14'd0, radius_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= accept;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= {31'd0, column_i} * {12'd0, cell_width_i};
    py_q     <= {31'd0, row_i} * {12'd0, cell_height_i};
    alt_a_q  <= current_altitude_i;
    rng_a_q  <= (32'(column_i) < MAX_COLUMNS) && (32'(row_i) < MAX_ROWS);
    item_b_q.alt    <= alt_a_q;
    item_b_q.pre_in <= pre_in;
    item_b_q.ax     <= ax[30:0];
    item_b_q.ay     <= ay[30:0];
  end

  assign push_o      = vld_b_q;
  assign push_item_o = item_b_q;

endmodule

`default_nettype wire

@@ hdl/rfr_fifo.sv @@
`default_nettype none

module rfr_fifo (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire rfr_pkg::item_t                  push_item_i,
  input  wire logic                            pop_i,
  output logic                                 valid_o,
  output rfr_pkg::item_t                       item_o,
  output logic [rfr_pkg::FIFO_CNT_W-1:0]       free_o
);

  localparam logic [rfr_pkg::FIFO_PTR_W-1:0] LAST = rfr_pkg::FIFO_PTR_W'(rfr_pkg::FIFO_DEPTH - 1);
  localparam logic [rfr_pkg::FIFO_CNT_W-1:0] FULL = rfr_pkg::FIFO_CNT_W'(rfr_pkg::FIFO_DEPTH);

  rfr_pkg::item_t mem_q [rfr_pkg::FIFO_DEPTH];
  logic [rfr_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [rfr_pkg::FIFO_CNT_W-1:0] count_q;
  logic do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_q];
  assign free_o  = FULL - count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !do_pop |-> count_q < FULL)
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

@@ hdl/rfr_back.sv @@
`default_nettype none

module rfr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fifo_valid_i,
  input  wire rfr_pkg::item_t fifo_item_i,
  output logic                pop_o,
  input  wire logic [30:0]    radius_i,
  input  wire logic [61:0]    radius_sq_i,
  input  wire logic [31:0]    amplitude_i,
  input  wire logic [15:0]    falloff_degree_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [31:0]         new_altitude_o,
  output logic                inside_brush_o,
  output logic                saturated_o
);

  localparam int RT_N = 32;
  localparam int DV_N = 16;
  localparam int SN_N = 10;
  localparam int LG_N = 22;
  localparam int EX_N = 17;
  localparam int CLAMP_ST = 2 + RT_N + DV_N + SN_N;
  localparam int NSTG = CLAMP_ST + LG_N + EX_N + 3;

  typedef struct packed {
    logic [31:0] alt;
    logic        in_brush;
    logic        szero;
  } side_t;

  typedef struct packed {
    logic [29:0]        x30;
    logic [29:0]        x2;
    logic signed [31:0] p;
    logic signed [63:0] prod;
  } sn_t;

  typedef struct packed {
    logic [30:0] m;
    logic [4:0]  e;
    logic [15:0] lg;
  } lg_t;

  typedef struct packed {
    logic [30:0] r;
    logic [15:0] fr;
    logic [4:0]  ip;
    logic        deep;
  } ex_t;

  function automatic logic signed [31:0] horner_coef(input int j);
    logic signed [31:0] c;
    case (j)
      2:       c = rfr_pkg::SIN_C7;
      4:       c = rfr_pkg::SIN_C5;
      6:       c = rfr_pkg::SIN_C3;
      default: c = rfr_pkg::SIN_C1;
    endcase
    return c;
  endfunction

  logic [NSTG-1:0] vld_q;
  logic adv;

  side_t side_q [NSTG-1];
  side_t side_d [NSTG-1];
  logic [61:0] ax2_q, ay2_q;
  logic [62:0] d2_q, d2_sum;
  logic [62:0] rv_q [RT_N];
  logic [62:0] rv_d [RT_N];
  logic [63:0] rr_q [RT_N];
  logic [63:0] rr_d [RT_N];
  logic [30:0] dr_q [DV_N];
  logic [30:0] dr_d [DV_N];
  logic [15:0] dq_q [DV_N];
  logic [15:0] dq_d [DV_N];
  sn_t sn_q [SN_N];
  sn_t sn_d [SN_N];
  lg_t lg_q [LG_N];
  lg_t lg_d [LG_N];
  ex_t ex_q [EX_N];
  ex_t ex_d [EX_N];
  logic [30:0] pw_q, pw_d;
  logic signed [63:0] am_q, am_d;
  logic [31:0] alt_d;
  logic sat_d;

  // The whole back part moves as one when the output register can take a result.
  assign adv   = !vld_q[NSTG-1] || !out_stall_i;
  assign pop_o = adv && fifo_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], fifo_valid_i};
    end
  end

  assign d2_sum = {1'b0, ax2_q} + {1'b0, ay2_q};

  // Square root, one result bit per stage.
  always_comb begin
    logic [62:0] vi;
    logic [63:0] ri, tr, bt;
    for (int k = 0; k < RT_N; k++) begin
      if (k == 0) begin
        vi = d2_q;
        ri = '0;
      end else begin
        vi = rv_q[k-1];
        ri = rr_q[k-1];
      end
      bt = 64'd1 << (2 * (RT_N - 1 - k));
      tr = ri + bt;
      if ({1'b0, vi} >= tr) begin
        rv_d[k] = 63'({1'b0, vi} - tr);
        rr_d[k] = (ri >> 1) + bt;
      end else begin
        rv_d[k] = vi;
        rr_d[k] = ri >> 1;
      end
    end
  end

  // Restoring division d / radius, one quotient bit per stage.
  always_comb begin
    logic [30:0] rem;
    logic [15:0] qi;
    logic [31:0] sh;
    logic ge;
    for (int j = 0; j < DV_N; j++) begin
      if (j == 0) begin
        rem = rr_q[RT_N-1][30:0];
        qi  = '0;
      end else begin
        rem = dr_q[j-1];
        qi  = dq_q[j-1];
      end
      sh = {rem, 1'b0};
      ge = (sh >= {1'b0, radius_i});
      dr_d[j] = ge ? 31'(sh - {1'b0, radius_i}) : sh[30:0];
      dq_d[j] = {qi[14:0], ge};
    end
  end

  // Sine polynomial, multiply and add on alternating stages.
  always_comb begin
    logic [29:0] x30;
    logic [59:0] xx;
    x30 = {dq_q[DV_N-1], 14'd0};
    xx  = {30'd0, x30} * {30'd0, x30};
    sn_d[0].x30  = x30;
    sn_d[0].x2   = xx[59:30];
    sn_d[0].p    = rfr_pkg::SIN_C9;
    sn_d[0].prod = '0;
    for (int j = 1; j < SN_N; j++) begin
      sn_d[j] = sn_q[j-1];
      if (j == SN_N - 1) begin
        sn_d[j].prod = $signed(sn_q[j-1].p) * $signed({2'b00, sn_q[j-1].x30});
      end else if (j % 2 == 1) begin
        sn_d[j].prod = $signed(sn_q[j-1].p) * $signed({2'b00, sn_q[j-1].x2});
      end else begin
        sn_d[j].p = horner_coef(j) + 32'(sn_q[j-1].prod >>> 30);
      end
    end
  end

  // Clamp, normalize, then the log2 fraction by repeated squaring.
  always_comb begin
    logic signed [63:0] sv;
    logic [61:0] mm;
    int sh;
    sv = sn_q[SN_N-1].prod >>> 30;
    lg_d[0].e  = '0;
    lg_d[0].lg = '0;
    if (sv < 0) begin
      lg_d[0].m = '0;
    end else if (sv > $signed({33'd0, rfr_pkg::Q30_ONE})) begin
      lg_d[0].m = rfr_pkg::Q30_ONE;
    end else begin
      lg_d[0].m = sv[30:0];
    end
    for (int j = 1; j < LG_N; j++) begin
      lg_d[j] = lg_q[j-1];
      mm = '0;
      sh = 0;
      if (j <= 5) begin
        sh = 32 >> j;
        if ((lg_q[j-1].m >> (31 - sh)) == '0) begin
          lg_d[j].m = 31'(lg_q[j-1].m << sh);
          lg_d[j].e = lg_q[j-1].e + 5'(sh);
        end
      end else begin
        mm = {31'd0, lg_q[j-1].m} * {31'd0, lg_q[j-1].m};
        if (mm[61]) begin
          lg_d[j].m  = mm[61:31];
          lg_d[j].lg = {lg_q[j-1].lg[14:0], 1'b1};
        end else begin
          lg_d[j].m  = mm[60:30];
          lg_d[j].lg = {lg_q[j-1].lg[14:0], 1'b0};
        end
      end
    end
  end

  // Exponent times degree, then 2^-fraction from the table.
  always_comb begin
    logic [20:0] nl;
    logic [36:0] mg;
    logic [60:0] rp;
    nl = {lg_q[LG_N-1].e, 16'd0} - {5'd0, lg_q[LG_N-1].lg};
    mg = {21'd0, falloff_degree_i} * {16'd0, nl};
    ex_d[0].r    = rfr_pkg::Q30_ONE;
    ex_d[0].fr   = mg[23:8];
    ex_d[0].ip   = mg[28:24];
    ex_d[0].deep = (mg[36:24] >= 13'd31);
    for (int j = 1; j < EX_N; j++) begin
      ex_d[j] = ex_q[j-1];
      rp = {30'd0, ex_q[j-1].r} * {31'd0, rfr_pkg::exp_tab(4'(j - 1))};
      if (ex_q[j-1].fr[16 - j]) begin
        ex_d[j].r = rp[60:30];
      end
    end
  end

  always_comb begin
    if (side_q[NSTG-4].szero) begin
      pw_d = (falloff_degree_i == '0) ? rfr_pkg::Q30_ONE : '0;
    end else if (ex_q[EX_N-1].deep) begin
      pw_d = '0;
    end else begin
      pw_d = ex_q[EX_N-1].r >> ex_q[EX_N-1].ip;
    end
    am_d = $signed(amplitude_i) * $signed({1'b0, rfr_pkg::Q30_ONE - pw_q});
  end

  // Saturating sum at the output register.
  always_comb begin
    logic signed [63:0] sum;
    sum = $signed({{32{side_q[NSTG-2].alt[31]}}, side_q[NSTG-2].alt}) + (am_q >>> 30);
    sat_d = 1'b0;
    if (sum > 64'sd2147483647) begin
      alt_d = 32'h7fff_ffff;
      sat_d = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      alt_d = 32'h8000_0000;
      sat_d = 1'b1;
    end else begin
      alt_d = sum[31:0];
    end
    if (!side_q[NSTG-2].in_brush) begin
      alt_d = side_q[NSTG-2].alt;
      sat_d = 1'b0;
    end
  end

  always_comb begin
    side_d[0].alt      = fifo_item_i.alt;
    side_d[0].in_brush = fifo_item_i.pre_in;
    side_d[0].szero    = 1'b0;
    for (int i = 1; i < NSTG - 1; i++) begin
      side_d[i] = side_q[i-1];
    end
    side_d[1].in_brush     = side_q[0].in_brush && (d2_sum < {1'b0, radius_sq_i});
    side_d[CLAMP_ST].szero = (lg_d[0].m == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax2_q  <= {31'd0, fifo_item_i.ax} * {31'd0, fifo_item_i.ax};
      ay2_q  <= {31'd0, fifo_item_i.ay} * {31'd0, fifo_item_i.ay};
      d2_q   <= d2_sum;
      side_q <= side_d;
      rv_q   <= rv_d;
      rr_q   <= rr_d;
      dr_q   <= dr_d;
      dq_q   <= dq_d;
      sn_q   <= sn_d;
      lg_q   <= lg_d;
      ex_q   <= ex_d;
      pw_q   <= pw_d;
      am_q   <= am_d;
      new_altitude_o <= alt_d;
      inside_brush_o <= side_q[NSTG-2].in_brush;
      saturated_o    <= sat_d;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];

endmodule

`default_nettype wire

@@ hdl/radial_falloff_raise_top.sv @@
`default_nettype none

// Radial falloff brush: each item names one height-grid cell (column, row,
// current altitude) and yields one result, the new altitude with an inside
// flag and a saturation flag. The cell offset from the brush center is
// column * cell_width + offset_x (likewise for rows); inside the radius the
// block adds amplitude * (1 - sin(pi/2 * d / radius)^falloff_degree) and
// saturates to the signed 32-bit range, outside it passes the altitude on.
// The block takes one item per clock cycle for as long as results are taken.
// A front part forms the offsets and the coarse inside test in two stages and
// writes into a four-entry queue; the back part is a 102-stage pipeline
// (square root and division one bit per stage, the sine polynomial, the
// log2 by repeated squaring, the power table, the scaling and the
// saturating add). An item passes the two front stages, the queue and the
// 102 back stages, the last of which is the output register. A stall on
// the output freezes the back part only, and the queue lets the front keep
// accepting until it is full. Configuration writes are always ready and take
// effect for items accepted after the write; registers must only be changed
// while no item is in flight.

module radial_falloff_raise_top #(
  parameter int unsigned MAX_COLUMNS = rfr_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = rfr_pkg::DEF_MAX_ROWS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] column_i,
  input  wire logic [11:0] row_i,
  input  wire logic [31:0] current_altitude_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      new_altitude_o,
  output logic             inside_brush_o,
  output logic             saturated_o
);

  logic [31:0] offset_x_q, offset_y_q, amplitude_q;
  logic [30:0] cell_width_q, cell_height_q, radius_q;
  logic [15:0] degree_q;
  logic [61:0] radius_sq_q;

  logic           push, pop, fifo_valid;
  rfr_pkg::item_t push_item, fifo_item;
  logic [rfr_pkg::FIFO_CNT_W-1:0] fifo_free;

  // The register port never pushes back; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= rfr_pkg::RST_OFFSET;
      offset_y_q    <= rfr_pkg::RST_OFFSET;
      cell_width_q  <= rfr_pkg::RST_SPAN;
      cell_height_q <= rfr_pkg::RST_SPAN;
      radius_q      <= rfr_pkg::RST_SPAN;
      amplitude_q   <= rfr_pkg::RST_AMP;
      degree_q      <= rfr_pkg::RST_DEGREE;
      radius_sq_q   <= {31'd0, rfr_pkg::RST_SPAN} * {31'd0, rfr_pkg::RST_SPAN};
    end else begin
      // The squared radius follows the radius register in the next cycle.
      radius_sq_q <= {31'd0, radius_q} * {31'd0, radius_q};
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rfr_pkg::CFG_OFFSET_X:    offset_x_q    <= cfg_data_i;
          rfr_pkg::CFG_OFFSET_Y:    offset_y_q    <= cfg_data_i;
          rfr_pkg::CFG_CELL_WIDTH:  cell_width_q  <= cfg_data_i[30:0];
          rfr_pkg::CFG_CELL_HEIGHT: cell_height_q <= cfg_data_i[30:0];
          rfr_pkg::CFG_RADIUS:      radius_q      <= cfg_data_i[30:0];
          rfr_pkg::CFG_AMPLITUDE:   amplitude_q   <= cfg_data_i;
          rfr_pkg::CFG_DEGREE:      degree_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  rfr_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .column_i           (column_i),
    .row_i              (row_i),
    .current_altitude_i (current_altitude_i),
    .offset_x_i         (offset_x_q),
    .offset_y_i         (offset_y_q),
    .cell_width_i       (cell_width_q),
    .cell_height_i      (cell_height_q),
    .radius_i           (radius_q),
    .fifo_free_i        (fifo_free),
    .push_o             (push),
    .push_item_o        (push_item)
  );

  rfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .item_o      (fifo_item),
    .free_o      (fifo_free)
  );

  rfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fifo_valid_i     (fifo_valid),
    .fifo_item_i      (fifo_item),
    .pop_o            (pop),
    .radius_i         (radius_q),
    .radius_sq_i      (radius_sq_q),
    .amplitude_i      (amplitude_q),
    .falloff_degree_i (degree_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .new_altitude_o   (new_altitude_o),
    .inside_brush_o   (inside_brush_o),
    .saturated_o      (saturated_o)
  );

endmodule

`default_nettype wire

@@ dv/radial_falloff_raise_top_test.sv @@
`default_nettype none

module radial_falloff_raise_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One grid cell as sent to the block.
  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] alt;
  } cell_t;

  // One updated cell as the block returns it.
  typedef struct {
    logic [31:0] alt;
    logic        in_brush;
    logic        sat;
  } altitude_t;

  // 2^(-2^-(k+1)) in Q30, the factors that build the falloff power.
  localparam longint POW_TAB [16] = '{
    759250125, 902905697, 984625594, 1028218693,
    1050733751, 1062175491, 1067942999, 1070838486,
    1072289186, 1073015247, 1073378474, 1073560134,
    1073650975, 1073696399, 1073719111, 1073730467
  };
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [11:0] column_i;
  logic [11:0] row_i;
  logic [31:0] current_altitude_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] new_altitude_o;
  logic        inside_brush_o;
  logic        saturated_o;

  radial_falloff_raise_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .column_i           (column_i),
    .row_i              (row_i),
    .current_altitude_i (current_altitude_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .new_altitude_o     (new_altitude_o),
    .inside_brush_o     (inside_brush_o),
    .saturated_o        (saturated_o)
  );

  // The brush settings as the testbench believes the block holds them.
  longint          brush_off_x, brush_off_y, brush_amp;
  longint unsigned brush_cw, brush_ch, brush_rad, brush_deg;

  cell_t     cells_to_send [$];
  altitude_t altitudes_due [$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        fail_count;

  // Computes the new altitude of one cell under the current brush. All the
  // fixed-point steps floor exactly as the block is specified to.
  function automatic altitude_t raise_cell(cell_t c);
    longint          dx, dy, x30, x2, p, s, pw, delta, sum, r;
    longint unsigned ax, ay, d2, d, t, v, bit_q, m, e, lg, nl, mm, ip, fr;
    altitude_t       res;
    res.alt      = c.alt;
    res.in_brush = 1'b0;
    res.sat      = 1'b0;
    if (c.col >= rfr_pkg::DEF_MAX_COLUMNS || c.row >= rfr_pkg::DEF_MAX_ROWS) return res;
    dx = longint'(c.col) * longint'(brush_cw) + brush_off_x;
    dy = longint'(c.row) * longint'(brush_ch) + brush_off_y;
    ax = (dx < 0) ? longint'(-dx) : dx;
    ay = (dy < 0) ? longint'(-dy) : dy;
    if (ax >= brush_rad || ay >= brush_rad) return res;
    d2 = ax * ax + ay * ay;
    if (d2 >= brush_rad * brush_rad) return res;
    res.in_brush = 1'b1;

    // Integer square root, one result bit per pass.
    v     = d2;
    d     = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > v) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (v >= d + bit_q) begin
        v = v - (d + bit_q);
        d = (d >> 1) + bit_q;
      end else begin
        d = d >> 1;
      end
      bit_q = bit_q >> 2;
    end
    t = (d << 16) / brush_rad;

    // Sine of the normalized distance by the odd polynomial in Q30.
    x30 = longint'(t << 14);
    x2  = (x30 * x30) >>> 30;
    p   = longint'(rfr_pkg::SIN_C9);
    p   = longint'(rfr_pkg::SIN_C7) + ((p * x2) >>> 30);
    p   = longint'(rfr_pkg::SIN_C5) + ((p * x2) >>> 30);
    p   = longint'(rfr_pkg::SIN_C3) + ((p * x2) >>> 30);
    p   = longint'(rfr_pkg::SIN_C1) + ((p * x2) >>> 30);
    s   = (p * x30) >>> 30;
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;

    // Power s^degree through log2 and the table of negative powers of two.
    // A zero sine gives one for a zero degree and zero otherwise.
    if (s <= 0) begin
      pw = (brush_deg == 0) ? ONE_Q30 : 0;
    end else begin
      m  = s;
      e  = 0;
      lg = 0;
      while (m < ONE_Q30) begin
        m = m << 1;
        e = e + 1;
      end
      for (int k = 15; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= 2 * ONE_Q30) begin
          m  = m >> 1;
          lg = lg | (64'd1 << k);
        end
      end
      nl = (e << 16) - lg;
      mm = (brush_deg * nl) >> 8;
      ip = mm >> 16;
      if (ip >= 31) begin
        pw = 0;
      end else begin
        fr = mm & 64'hFFFF;
        r  = ONE_Q30;
        for (int k = 0; k < 16; k++) begin
          if (fr[15 - k]) r = longint'((longint'(r) * POW_TAB[k]) >> 30);
        end
        pw = r >>> ip;
      end
    end

    delta = (brush_amp * (ONE_Q30 - pw)) >>> 30;
    sum   = longint'($signed(c.alt)) + delta;
    if (sum > 64'sd2147483647) begin
      sum     = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum     = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.alt = sum[31:0];
    return res;
  endfunction

  // Clock with a 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver. A cell waiting on a stall stays on the pins unchanged; otherwise
  // the next pending cell is offered unless the sender chooses to idle. Each
  // accepted cell gets its expected altitude computed right away, which is
  // safe because settings only change while nothing is in flight.
  always @(posedge clk_i or negedge rst_ni) begin
    cell_t c;
    if (!rst_ni) begin
      in_valid_i         <= 1'b0;
      column_i           <= '0;
      row_i              <= '0;
      current_altitude_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        c.col = column_i;
        c.row = row_i;
        c.alt = current_altitude_i;
        altitudes_due.push_back(raise_cell(c));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (cells_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cells_to_send.pop_front();
          in_valid_i         <= 1'b1;
          column_i           <= c.col;
          row_i              <= c.row;
          current_altitude_i <= c.alt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall. Every result taken is compared field by
  // field with the oldest expected altitude.
  always @(posedge clk_i or negedge rst_ni) begin
    altitude_t exp_alt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (altitudes_due.size() == 0) begin
          $error("result with no item outstanding: new_altitude %0h", new_altitude_o);
          fail_count++;
        end else begin
          exp_alt = altitudes_due.pop_front();
          if (new_altitude_o !== exp_alt.alt) begin
            $error("new_altitude: expected %0h, actual %0h", exp_alt.alt, new_altitude_o);
            fail_count++;
          end
          if (inside_brush_o !== exp_alt.in_brush) begin
            $error("inside_brush: expected %0b, actual %0b", exp_alt.in_brush,
                   inside_brush_o);
            fail_count++;
          end
          if (saturated_o !== exp_alt.sat) begin
            $error("saturated: expected %0b, actual %0b", exp_alt.sat, saturated_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Writes one register and mirrors it into the predictor's settings once
  // the block has taken it.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      rfr_pkg::CFG_OFFSET_X:    brush_off_x = longint'($signed(data));
      rfr_pkg::CFG_OFFSET_Y:    brush_off_y = longint'($signed(data));
      rfr_pkg::CFG_CELL_WIDTH:  brush_cw    = data[30:0];
      rfr_pkg::CFG_CELL_HEIGHT: brush_ch    = data[30:0];
      rfr_pkg::CFG_RADIUS:      brush_rad   = data[30:0];
      rfr_pkg::CFG_AMPLITUDE:   brush_amp   = longint'($signed(data));
      rfr_pkg::CFG_DEGREE:      brush_deg   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_brush(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] cw, input logic [31:0] ch,
                             input logic [31:0] rad, input logic [31:0] amp,
                             input logic [31:0] deg);
    write_reg(rfr_pkg::CFG_OFFSET_X, ox);
    write_reg(rfr_pkg::CFG_OFFSET_Y, oy);
    write_reg(rfr_pkg::CFG_CELL_WIDTH, cw);
    write_reg(rfr_pkg::CFG_CELL_HEIGHT, ch);
    write_reg(rfr_pkg::CFG_RADIUS, rad);
    write_reg(rfr_pkg::CFG_AMPLITUDE, amp);
    write_reg(rfr_pkg::CFG_DEGREE, deg);
  endtask

  task automatic queue_cell(input logic [11:0] col, input logic [11:0] row,
                            input logic [31:0] alt);
    cell_t c;
    c.col = col;
    c.row = row;
    c.alt = alt;
    cells_to_send.push_back(c);
  endtask

  // Waits until every cell has been sent and answered, then lets the
  // pipeline run dry, since the back part is 102 stages deep.
  task automatic wait_drained();
    while (cells_to_send.size() != 0 || in_valid_i || altitudes_due.size() != 0)
      @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  // Main sequence: directed cells at a few hand-picked brushes, then random
  // brushes with mostly cells around the brush center.
  initial begin
    int          cx, cy, span_x, span_y, col, row;
    logic [31:0] cw, ch, rad, alt;
    longint      lim;
    fail_count    = 0;
    send_idle_pct = 28;
    recv_idle_pct = 70;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = rfr_pkg::CFG_OFFSET_X;
    cfg_data_i    = '0;
    brush_off_x   = 0;
    brush_off_y   = 0;
    brush_cw      = 65536;
    brush_ch      = 65536;
    brush_rad     = 65536;
    brush_amp     = 0;
    brush_deg     = 256;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: only the origin cell is inside, with zero amplitude.
    queue_cell(12'd0, 12'd0, 32'h7FFF_FFFF);
    queue_cell(12'd4095, 12'd4095, 32'h8000_0000);
    queue_cell(12'd1, 12'd0, 32'h0000_1234);
    wait_drained();

    // Full amplitude at the exact center: a zero sine and a nonzero degree
    // give the whole amplitude, and a top altitude overflows.
    write_brush(32'hFFFB_0000, 32'hFFFB_0000, 32'd65536, 32'd65536,
                32'd5 << 16, 32'h7FFF_FFFF, 32'd256);
    queue_cell(12'd5, 12'd5, 32'h7FFF_FFFF);
    queue_cell(12'd5, 12'd5, 32'h0000_0000);
    queue_cell(12'd7, 12'd6, 32'h1000_0000);
    queue_cell(12'd9, 12'd5, 32'h0000_0000);
    queue_cell(12'd10, 12'd5, 32'h0000_0000);
    queue_cell(12'd0, 12'd5, 32'h0000_0000);
    wait_drained();

    // Zero degree: inside but unchanged, including a zero sine at the center.
    write_reg(rfr_pkg::CFG_DEGREE, 32'd0);
    write_reg(rfr_pkg::CFG_AMPLITUDE, 32'h8000_0000);
    queue_cell(12'd5, 12'd5, 32'h8000_0000);
    queue_cell(12'd6, 12'd4, 32'h0000_0042);
    wait_drained();

    // Deepest degree drives the power to zero; negative amplitude underflows.
    write_reg(rfr_pkg::CFG_DEGREE, 32'h0000_FFFF);
    queue_cell(12'd8, 12'd7, 32'h8000_0000);
    queue_cell(12'd5, 12'd6, 32'h0000_0000);
    queue_cell(12'd5, 12'd5, 32'h8000_0001);
    wait_drained();

    // Smallest radius and largest spans, extreme offsets; an unknown
    // register index must leave every setting alone.
    write_brush(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'd1, 32'h0001_0000, 32'd128);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_cell(12'd1, 12'd0, 32'h0000_0000);
    queue_cell(12'd0, 12'd0, 32'h0000_0000);
    queue_cell(12'd4095, 12'd4095, 32'hFFFF_FFFF);
    wait_drained();
    write_reg(rfr_pkg::CFG_OFFSET_X, 32'h8000_0001);
    write_reg(rfr_pkg::CFG_OFFSET_Y, 32'h8000_0001);
    write_reg(rfr_pkg::CFG_RADIUS, 32'h7FFF_FFFF);
    queue_cell(12'd1, 12'd1, 32'h0000_0000);
    queue_cell(12'd0, 12'd0, 32'h7FFF_0000);
    wait_drained();

    // Random brushes. Most cells land near the brush center so that the
    // sine, power and saturation paths all get exercised.
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 5) begin
        send_idle_pct = 70;
        recv_idle_pct = 28;
      end else if (ph == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cw  = (ph % 4 == 3) ? {1'b0, 31'($urandom)} : 32'($urandom_range(1 << 18, 1 << 10));
      ch  = (ph % 4 == 3) ? {1'b0, 31'($urandom)} : 32'($urandom_range(1 << 18, 1 << 10));
      if (cw == 0) cw = 1;
      if (ch == 0) ch = 1;
      rad = 32'(cw) * 32'($urandom_range(40, 2));
      if (rad[31] || rad == 0) rad = {1'b0, 31'($urandom)} | 32'd1;
      lim = 64'sd2147483647 / longint'(cw);
      cx  = (lim > 4095) ? $urandom_range(4095) : $urandom_range(int'(lim));
      lim = 64'sd2147483647 / longint'(ch);
      cy  = (lim > 4095) ? $urandom_range(4095) : $urandom_range(int'(lim));
      write_brush(32'(-(longint'(cx) * longint'(cw))) + 32'($urandom_range(65535)),
                  32'(-(longint'(cy) * longint'(ch))) + 32'($urandom_range(65535)),
                  cw, ch, rad, $urandom,
                  (ph % 3 == 2) ? 32'($urandom_range(65535)) : 32'($urandom_range(2048)));
      if (ph % 5 == 4) write_reg(CFG_UNUSED, $urandom);
      span_x = int'(longint'(rad) / longint'(cw)) + 2;
      span_y = int'(longint'(rad) / longint'(ch)) + 2;
      for (int i = 0; i < 95; i++) begin
        case ($urandom_range(9))
          0, 1: begin
            queue_cell(12'($urandom), 12'($urandom), $urandom);
          end
          default: begin
            col = cx + $urandom_range(2 * span_x) - span_x;
            row = cy + $urandom_range(2 * span_y) - span_y;
            if (col < 0) col = 0;
            if (col > 4095) col = 4095;
            if (row < 0) row = 0;
            if (row > 4095) row = 4095;
            case ($urandom_range(3))
              0: alt = 32'h7FFF_FFFF - $urandom_range(1 << 20);
              1: alt = 32'h8000_0000 + $urandom_range(1 << 20);
              default: alt = $urandom;
            endcase
            queue_cell(col[11:0], row[11:0], alt);
          end
        endcase
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
